### rtl/assert_macros.svh
// Assertion macros shared by the queue and back-end RTL modules of the sensor frame builder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SFB_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SFB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/sfb_pkg.sv
// Types, constants and the CRC step function of the sensor frame builder.
package sfb_pkg;

  // One measurement set as it arrives.
  typedef struct packed {
    logic        [15:0] co2_ppm;
    logic signed [15:0] scd_temp;
    logic        [15:0] scd_humidity;
    logic signed [15:0] baro_temp;
    logic        [16:0] baro_pressure;
    logic               gas_ok;
    logic               baro_ok;
  } sample_t;

  // One frame byte as it leaves.
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } result_t;

  localparam int PAYLOAD_BYTES = 12;
  localparam int HEADER_BYTES  = 5;
  localparam int CRC_SPAN      = HEADER_BYTES + PAYLOAD_BYTES;
  localparam int FRAME_BYTES   = CRC_SPAN + 2;
  localparam int IDX_W         = $clog2(FRAME_BYTES);
  localparam int PSEL_W        = $clog2(PAYLOAD_BYTES);
  localparam int QUEUE_DEPTH   = 2;

  // Payload byte 0 is frame byte 5.
  typedef logic [PAYLOAD_BYTES-1:0][7:0] payload_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

  localparam logic [7:0]  HDR_SYNC0   = 8'hDE;
  localparam logic [7:0]  HDR_SYNC1   = 8'hAD;
  localparam logic [7:0]  HDR_SYNC2   = 8'hFF;
  localparam logic [7:0]  HDR_TYPE    = 8'h09;
  localparam logic [7:0]  PAYLOAD_LEN = 8'h0C;
  localparam logic [7:0]  FILL_BYTE   = 8'hFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;

  // One byte of the reflected Modbus CRC, eight bit steps.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### rtl/sfb_front.sv
// Front end: takes a measurement set and lays out the frame payload.
module sfb_front
  import sfb_pkg::*;
(
  input  logic          start,
  input  sample_t       sample,
  input  queue_status_t q_status,
  output logic          busy,
  output logic          push,
  output payload_t      payload
);

  // A transfer happens whenever start is high and the queue has room.
  assign busy = q_status.full;
  assign push = start && !q_status.full;

  // Big-endian layout; a failed sensor sends fill bytes.
  always_comb begin
    payload = '0;
    if (sample.gas_ok) begin
      payload[0] = sample.co2_ppm[15:8];
      payload[1] = sample.co2_ppm[7:0];
      payload[2] = sample.scd_temp[15:8];
      payload[3] = sample.scd_temp[7:0];
      payload[4] = sample.scd_humidity[15:8];
      payload[5] = sample.scd_humidity[7:0];
    end else begin
      for (int i = 0; i < 6; i++) begin
        payload[i] = FILL_BYTE;
      end
    end
    if (sample.baro_ok) begin
      payload[6]  = sample.baro_temp[15:8];
      payload[7]  = sample.baro_temp[7:0];
      payload[8]  = 8'h00;
      payload[9]  = {7'h00, sample.baro_pressure[16]};
      payload[10] = sample.baro_pressure[15:8];
      payload[11] = sample.baro_pressure[7:0];
    end else begin
      for (int i = 6; i < PAYLOAD_BYTES; i++) begin
        payload[i] = FILL_BYTE;
      end
    end
  end

endmodule

### rtl/sfb_queue.sv
// Short queue of laid-out payloads between the front and the back.
`include "assert_macros.svh"
module sfb_queue
  import sfb_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  payload_t      push_data,
  input  logic          pop,
  output payload_t      pop_data,
  output queue_status_t status
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  payload_t               entries [QUEUE_DEPTH];
  logic     [PTR_W-1:0]   wr_ptr;
  logic     [PTR_W-1:0]   rd_ptr;
  logic     [CNT_W-1:0]   count;

  assign status.empty = (count == '0);
  assign status.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign pop_data     = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  `SFB_ASSERT_SAME(a_no_push_full, clk, rst, push, !status.full, "push into full queue")
  `SFB_ASSERT_SAME(a_no_pop_empty, clk, rst, pop, !status.empty, "pop from empty queue")
  `SFB_ASSERT_SAME(a_count_range, clk, rst, 1'b1, count <= CNT_W'(QUEUE_DEPTH),
                   "queue count out of range")

endmodule

### rtl/sfb_back.sv
// Back end: serializes one frame a byte per cycle and appends the CRC.
`include "assert_macros.svh"
module sfb_back
  import sfb_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  queue_status_t q_status,
  input  payload_t      q_data,
  output logic          pop,
  output logic          strobe,
  output result_t       result
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);
  localparam logic [IDX_W-1:0] CRC_LO   = IDX_W'(CRC_SPAN);
  localparam logic [IDX_W-1:0] PAY_IDX  = IDX_W'(HEADER_BYTES);

  logic                active;
  logic [IDX_W-1:0]    idx;
  logic [15:0]         crc;
  payload_t            frame;
  logic [7:0]          cur_byte;
  logic [PSEL_W-1:0]   pay_sel;
  logic                load;

  // A new frame starts, if the queue holds one, when idle or on the last byte of the current one.
  assign load = !active || (idx == LAST_IDX);
  assign pop  = load && !q_status.empty;

  assign pay_sel = PSEL_W'(idx - PAY_IDX);

  // Byte for the current position.
  always_comb begin
    case (idx)
      IDX_W'(0): cur_byte = HDR_SYNC0;
      IDX_W'(1): cur_byte = HDR_SYNC1;
      IDX_W'(2): cur_byte = HDR_SYNC2;
      IDX_W'(3): cur_byte = HDR_TYPE;
      IDX_W'(4): cur_byte = PAYLOAD_LEN;
      CRC_LO:    cur_byte = crc[7:0];
      LAST_IDX:  cur_byte = crc[15:8];
      default:   cur_byte = frame[pay_sel];
    endcase
  end

  // Sequencing, CRC and the output strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx    <= '0;
      crc    <= CRC_INIT;
      strobe <= 1'b0;
    end else begin
      strobe <= active;
      if (pop) begin
        active <= 1'b1;
        idx    <= '0;
        crc    <= CRC_INIT;
      end else if (active && idx == LAST_IDX) begin
        active <= 1'b0;
      end else if (active) begin
        idx <= idx + 1'b1;
        if (idx < CRC_LO) begin
          crc <= crc_byte(crc, cur_byte);
        end
      end
    end
  end

  // Payload hold and output register.
  always_ff @(posedge clk) begin
    if (pop) begin
      frame <= q_data;
    end
    result.frame_byte <= cur_byte;
    result.last_byte  <= active && (idx == LAST_IDX);
  end

  `SFB_ASSERT_SAME(a_last_has_strobe, clk, rst, result.last_byte, strobe,
                   "last byte flagged without strobe")
  `SFB_ASSERT_NEXT(a_frame_unbroken, clk, rst, active && idx != LAST_IDX,
                   active && idx == $past(idx) + 1'b1, "frame interrupted")
  `SFB_ASSERT_NEXT(a_next_frame_header, clk, rst, strobe && result.last_byte,
                   !strobe || result.frame_byte == HDR_SYNC0,
                   "frame after last byte does not open with header")

endmodule

### rtl/sensor_frame_builder_crc16.sv
// Top level of the sensor frame builder with Modbus CRC16.
//
// Channel   Direction  Handshake                     Payload
// sample    in         start high, busy low          sample_t (one measurement set)
// result    out        strobe high for one cycle     result_t (one frame byte)
//
// Each measurement set gives 19 bytes on consecutive cycles, one per cycle, set by the
// byte serializer in the back end; frames follow with no gap while a set is queued.
// Each set is registered in the queue, then the serializer, then the output register.
// A two-entry queue holds sets waiting for the serializer; busy is high when it is full.
// Reset clears the queue and the serializer; no clearing pass is needed.
// The receiver cannot stall; every byte is shown for exactly one cycle.
module sensor_frame_builder_crc16
  import sfb_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  sample_t sample,
  output logic    busy,
  output logic    strobe,
  output result_t result
);

  queue_status_t q_status;
  logic          push;
  logic          pop;
  payload_t      push_data;
  payload_t      pop_data;

  sfb_front u_front (
    .start    (start),
    .sample   (sample),
    .q_status (q_status),
    .busy     (busy),
    .push     (push),
    .payload  (push_data)
  );

  sfb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  sfb_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_status (q_status),
    .q_data   (pop_data),
    .pop      (pop),
    .strobe   (strobe),
    .result   (result)
  );

endmodule

### sim/tb_sensor_frame_builder_crc16.sv
// Self-checking testbench for the sensor frame builder with Modbus CRC16 framing.
module tb_sensor_frame_builder_crc16
  import sfb_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_BYTES      = 19;
  localparam int RANDOM_ITEMS   = 395;
  localparam int STEADY_TAIL    = 60;
  localparam int DRAIN_CYCLES   = 30;
  localparam int CYCLE_LIMIT    = 200000;

  // Holds the frame bytes still owed by the block and checks each one on arrival.
  class frame_scoreboard;
    result_t expected_bytes[$];
    int      errors;
    int      byte_pos;

    function new();
      errors   = 0;
      byte_pos = 0;
    endfunction

    // Builds the whole frame for one accepted measurement set.
    function void note_sample(sample_t s);
      logic [7:0]  fr[NUM_BYTES];
      logic [15:0] crc;
      logic [31:0] press;
      result_t     r;
      int          i;
      int          k;
      press = {15'd0, s.baro_pressure};
      fr[0] = 8'hDE;
      fr[1] = 8'hAD;
      fr[2] = 8'hFF;
      fr[3] = 8'h09;
      fr[4] = 8'h0C;
      // A failed sensor sends its whole block as 0xFF.
      if (s.gas_ok) begin
        fr[5]  = s.co2_ppm[15:8];
        fr[6]  = s.co2_ppm[7:0];
        fr[7]  = s.scd_temp[15:8];
        fr[8]  = s.scd_temp[7:0];
        fr[9]  = s.scd_humidity[15:8];
        fr[10] = s.scd_humidity[7:0];
      end else begin
        for (i = 5; i <= 10; i++) fr[i] = 8'hFF;
      end
      if (s.baro_ok) begin
        fr[11] = s.baro_temp[15:8];
        fr[12] = s.baro_temp[7:0];
        fr[13] = press[31:24];
        fr[14] = press[23:16];
        fr[15] = press[15:8];
        fr[16] = press[7:0];
      end else begin
        for (i = 11; i <= 16; i++) fr[i] = 8'hFF;
      end
      // Reflected CRC, shifted out one bit at a time, LSB of each byte first.
      crc = 16'hFFFF;
      for (i = 0; i < NUM_BYTES - 2; i++) begin
        for (k = 0; k < 8; k++) begin
          if (crc[0] ^ fr[i][k]) begin
            crc = (crc >> 1) ^ 16'hA001;
          end else begin
            crc = crc >> 1;
          end
        end
      end
      fr[17] = crc[7:0];
      fr[18] = crc[15:8];
      for (i = 0; i < NUM_BYTES; i++) begin
        r.frame_byte = fr[i];
        r.last_byte  = (i == NUM_BYTES - 1);
        expected_bytes.push_back(r);
      end
    endfunction

    // Compares one transfer on the result port with the oldest owed byte.
    function void check_byte(result_t got);
      result_t want;
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected frame byte, expected none, actual %h/%b",
                 $time, got.frame_byte, got.last_byte);
        errors++;
        return;
      end
      want = expected_bytes.pop_front();
      if (got.frame_byte !== want.frame_byte) begin
        $display("%0t: frame_byte at offset %0d, expected %h, actual %h",
                 $time, byte_pos, want.frame_byte, got.frame_byte);
        errors++;
      end
      if (got.last_byte !== want.last_byte) begin
        $display("%0t: last_byte at offset %0d, expected %b, actual %b",
                 $time, byte_pos, want.last_byte, got.last_byte);
        errors++;
      end
      byte_pos = (byte_pos + 1) % NUM_BYTES;
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  sample_t     sample;
  logic        busy;
  logic        strobe;
  result_t     result;
  int unsigned cycle_count = 0;

  frame_scoreboard sb = new();

  sensor_frame_builder_crc16 dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .sample (sample),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
  );

  // Free-running 4 ns clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watch both ports on each rising edge and feed the scoreboard.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_sample(sample);
      if (strobe) sb.check_byte(result);
    end
  end

  // The cycle counter bounds the run.
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  function automatic sample_t make_sample(logic [15:0] co2, logic [15:0] st,
                                          logic [15:0] hum, logic [15:0] bt,
                                          logic [16:0] pr, logic g, logic b);
    sample_t s;
    s.co2_ppm       = co2;
    s.scd_temp      = st;
    s.scd_humidity  = hum;
    s.baro_temp     = bt;
    s.baro_pressure = pr;
    s.gas_ok        = g;
    s.baro_ok       = b;
    return s;
  endfunction

  // Random field picks, with the field extremes mixed in now and then.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    s.co2_ppm       = 16'(pick_value());
    s.scd_temp      = 16'(pick_value());
    s.scd_humidity  = 16'(pick_value());
    s.baro_temp     = 16'(pick_value());
    s.baro_pressure = 17'(pick_value());
    s.gas_ok        = ($urandom_range(0, 5) != 0);
    s.baro_ok       = ($urandom_range(0, 5) != 0);
    return s;
  endfunction

  // Present one set and hold it until the transfer happens.
  task automatic drive_sample(sample_t s);
    start  <= 1'b1;
    sample <= s;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Leave start low for a random burst while the data lines carry noise.
  task automatic idle_burst();
    start  <= 1'b0;
    sample <= random_sample();
    repeat ($urandom_range(1, 17)) @(posedge clk);
  endtask

  // Main sequence: reset, directed sets, random sets, then drain.
  initial begin
    int n;
    bit quiet;
    rst    <= 1'b1;
    start  <= 1'b0;
    sample <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Field extremes, sign patterns and both sensor failure cases.
    drive_sample(make_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 17'h00000, 1'b1, 1'b1));
    drive_sample(make_sample(16'hFFFF, 16'h7FFF, 16'hFFFF, 16'h7FFF, 17'h1FFFF, 1'b1, 1'b1));
    drive_sample(make_sample(16'h0000, 16'h8000, 16'h0000, 16'h8000, 17'h00000, 1'b1, 1'b1));
    drive_sample(make_sample(16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF, 17'h00001, 1'b1, 1'b1));
    drive_sample(make_sample(16'd415, 16'd2345, 16'd4512, -16'sd512, 17'd101325, 1'b1, 1'b1));
    drive_sample(make_sample(16'd415, 16'd2345, 16'd4512, -16'sd512, 17'd101325, 1'b0, 1'b1));
    drive_sample(make_sample(16'd415, 16'd2345, 16'd4512, -16'sd512, 17'd101325, 1'b1, 1'b0));
    drive_sample(make_sample(16'd415, 16'd2345, 16'd4512, -16'sd512, 17'd101325, 1'b0, 1'b0));
    idle_burst();
    drive_sample(make_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 17'h10000, 1'b1, 1'b1));
    drive_sample(make_sample(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 17'h15555, 1'b1, 1'b1));
    drive_sample(make_sample(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 17'h0AAAA, 1'b1, 1'b1));
    idle_burst();
    drive_sample(make_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 17'h00000, 1'b0, 1'b0));
    drive_sample(make_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 17'h1FFFF, 1'b0, 1'b0));
    drive_sample(make_sample(16'hFFFF, 16'h8000, 16'hFFFF, 16'h7FFF, 17'h0FFFF, 1'b1, 1'b0));
    drive_sample(make_sample(16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 17'h1FFFF, 1'b0, 1'b1));

    // Random sets; every third stretch of 30 runs without gaps, and so does the tail.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      drive_sample(random_sample());
      quiet = ((n / 30) % 3 == 2) || (n >= RANDOM_ITEMS - STEADY_TAIL);
      if (!quiet && $urandom_range(0, 9) < 6) idle_burst();
    end
    start <= 1'b0;

    // Wait for every owed byte, then keep watching for strays.
    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
